/* design/linked_buffer_queue_manager_unit_defines.svh */
// Assertion macros for the linked buffer queue manager.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef LINKED_BUFFER_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define LINKED_BUFFER_QUEUE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define LBQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lbq_pkg.sv */
// Package for the linked buffer queue manager: sizes, link and entry types,
// request and state codes, memory request structs. No dependencies.
`default_nettype none

package lbq_pkg;

	localparam int SLOT_COUNT    = 64;
	localparam int MAILBOX_COUNT = 16;
	localparam int SLOT_W        = $clog2(SLOT_COUNT);
	localparam int MB_W          = $clog2(MAILBOX_COUNT);
	localparam int LINK_W        = SLOT_W + 1;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [MB_W-1:0]   mb_t;

	localparam link_t NULL_LINK = LINK_W'(SLOT_COUNT);

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_ENQ   = 2'd2,
		REQ_DEQ   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_S1,
		ST_S2
	} state_t;

	typedef struct packed {
		link_t head;
		link_t tail;
	} qent_t;

	typedef struct packed {
		logic  rd;
		slot_t rd_addr;
		logic  wr;
		slot_t wr_addr;
		link_t wr_data;
	} link_req_t;

	typedef struct packed {
		logic  rd;
		mb_t   rd_addr;
		logic  wr;
		mb_t   wr_addr;
		qent_t wr_data;
	} q_req_t;

	function automatic logic is_slot(input link_t l);
		return l < NULL_LINK;
	endfunction

	// start-up free list: slot i links to i-1, slot 0 ends the list
	function automatic link_t link_reset(input slot_t a);
		return (a == '0) ? NULL_LINK : (LINK_W'(a) - LINK_W'(1));
	endfunction

endpackage

`default_nettype wire

/* design/lbq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/lbq_link_mem.sv */
// Next-link store: one RAM entry per slot plus per-entry valid bits that
// stand in for the start-up free list. Depends on lbq_pkg and lbq_ram.
`default_nettype none

module lbq_link_mem
	import lbq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire link_req_t req,
	output link_t          rd_data
);

	logic [SLOT_COUNT-1:0] vld_q;
	logic                  rd_vld_s1;
	slot_t                 rd_addr_s1;
	link_t                 ram_data;

	lbq_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (req.wr),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd),
		.raddr (req.rd_addr),
		.rdata (ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
		end else begin
			if (req.wr) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_s1  <= vld_q[req.rd_addr];
				rd_addr_s1 <= req.rd_addr;
			end
		end
	end

	assign rd_data = rd_vld_s1 ? ram_data : link_reset(rd_addr_s1);

endmodule

`default_nettype wire

/* design/lbq_queue_mem.sv */
// Mailbox head/tail store: one RAM entry per mailbox, valid bits give
// empty queues until written. Depends on lbq_pkg and lbq_ram.
`default_nettype none

module lbq_queue_mem
	import lbq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire q_req_t req,
	output qent_t       rd_data
);

	logic [MAILBOX_COUNT-1:0] vld_q;
	logic                     rd_vld_s1;
	qent_t                    ram_data;

	lbq_ram #(
		.WIDTH ($bits(qent_t)),
		.DEPTH (MAILBOX_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (req.wr),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd),
		.raddr (req.rd_addr),
		.rdata (ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? ram_data : qent_t'{head: NULL_LINK, tail: NULL_LINK};

endmodule

`default_nettype wire

/* design/linked_buffer_queue_manager_unit.sv */
// Linked buffer queue manager: a pool of SLOT_COUNT slots on one LIFO free list and
// MAILBOX_COUNT linked FIFO queues. Each transaction allocates, frees, enqueues or
// dequeues and gives one result transaction. Allocate, free and enqueue to an empty
// mailbox finish in ST_S1; enqueue to a non-empty mailbox and dequeue of a
// non-empty mailbox go on to ST_S2, as the link and queue memories have registered reads
// (a dequeue reads the queue head, then that slot's link). One transaction is in
// work at a time; a result waiting in the output register holds the last step only.
// The start-up state comes from valid bits, so there is no clearing pass after reset.
// Depends on lbq_pkg, lbq_link_mem, lbq_queue_mem and the assertion macro header.
`default_nettype none
`include "linked_buffer_queue_manager_unit_defines.svh"

module linked_buffer_queue_manager_unit
	import lbq_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   req_type,
	input  wire logic [MB_W-1:0]   mailbox_idx,
	input  wire logic [SLOT_W-1:0] slot_in,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [SLOT_W-1:0] slot_out,
	output logic              slot_valid
);

	state_t    state_q, state_d;
	req_t      req_q;
	mb_t       mb_q;
	slot_t     slot_q;
	link_t     free_head_q, free_head_d;
	logic      free_head_we;
	qent_t     ent_q;
	logic      ent_we;
	logic      out_valid_q, res_vld_q;
	slot_t     res_slot_q;

	link_req_t lreq;
	q_req_t    qreq;
	link_t     l_rd_data;
	qent_t     q_rd_data;

	logic      adv, fin, res_vld, accept, mb_ok, slot_ok, tail_slot;
	slot_t     res_slot;

	lbq_link_mem u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (lreq),
		.rd_data (l_rd_data)
	);

	lbq_queue_mem u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (qreq),
		.rd_data (q_rd_data)
	);

	assign adv       = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign mb_ok     = {1'b0, mb_q} < (MB_W+1)'(MAILBOX_COUNT);
	assign slot_ok   = is_slot({1'b0, slot_q});
	assign tail_slot = is_slot(q_rd_data.tail);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_S1;
				end
			end
			ST_S1: begin
				if (!fin) begin
					state_d = ST_S2;
				end else if (adv) begin
					state_d = ST_IDLE;
				end
			end
			ST_S2: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		fin          = 1'b0;
		res_vld      = 1'b0;
		res_slot     = '0;
		free_head_we = 1'b0;
		free_head_d  = free_head_q;
		ent_we       = 1'b0;
		lreq         = '0;
		qreq         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					qreq.rd      = 1'b1;
					qreq.rd_addr = mailbox_idx;
					lreq.rd      = is_slot(free_head_q);
					lreq.rd_addr = free_head_q[SLOT_W-1:0];
				end
			end
			ST_S1: begin
				case (req_q)
					REQ_ALLOC: begin
						fin = 1'b1;
						if (is_slot(free_head_q)) begin
							res_vld  = 1'b1;
							res_slot = free_head_q[SLOT_W-1:0];
							if (adv) begin
								free_head_we = 1'b1;
								free_head_d  = l_rd_data;
								lreq.wr      = 1'b1;
								lreq.wr_addr = free_head_q[SLOT_W-1:0];
								lreq.wr_data = NULL_LINK;
							end
						end
					end
					REQ_FREE: begin
						fin = 1'b1;
						if (slot_ok && adv) begin
							lreq.wr      = 1'b1;
							lreq.wr_addr = slot_q;
							lreq.wr_data = free_head_q;
							free_head_we = 1'b1;
							free_head_d  = {1'b0, slot_q};
						end
					end
					REQ_ENQ: begin
						if (!(mb_ok && slot_ok)) begin
							fin = 1'b1;
						end else begin
							fin = !tail_slot;
							if (adv || tail_slot) begin
								lreq.wr      = 1'b1;
								lreq.wr_addr = slot_q;
								lreq.wr_data = NULL_LINK;
								qreq.wr      = 1'b1;
								qreq.wr_addr = mb_q;
								qreq.wr_data.head = tail_slot ? q_rd_data.head : {1'b0, slot_q};
								qreq.wr_data.tail = {1'b0, slot_q};
								ent_we       = 1'b1;
							end
						end
					end
					REQ_DEQ: begin
						if (!(mb_ok && is_slot(q_rd_data.head))) begin
							fin = 1'b1;
						end else begin
							lreq.rd      = 1'b1;
							lreq.rd_addr = q_rd_data.head[SLOT_W-1:0];
							ent_we       = 1'b1;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_S2: begin
				fin = 1'b1;
				if (req_q == REQ_DEQ) begin
					res_vld  = 1'b1;
					res_slot = ent_q.head[SLOT_W-1:0];
					if (adv) begin
						qreq.wr      = 1'b1;
						qreq.wr_addr = mb_q;
						qreq.wr_data = is_slot(l_rd_data) ?
							qent_t'{head: l_rd_data, tail: ent_q.tail} :
							qent_t'{head: NULL_LINK, tail: NULL_LINK};
						lreq.wr      = 1'b1;
						lreq.wr_addr = ent_q.head[SLOT_W-1:0];
						lreq.wr_data = NULL_LINK;
					end
				end else if (adv) begin
					// link old tail to the new slot
					lreq.wr      = 1'b1;
					lreq.wr_addr = ent_q.tail[SLOT_W-1:0];
					lreq.wr_data = {1'b0, slot_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= LINK_W'(SLOT_COUNT - 1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (free_head_we) begin
				free_head_q <= free_head_d;
			end
			if (state_q != ST_IDLE && fin && adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_t'(req_type);
			mb_q   <= mailbox_idx;
			slot_q <= slot_in;
		end
		if (ent_we) begin
			ent_q <= q_rd_data;
		end
		if (state_q != ST_IDLE && fin && adv) begin
			res_vld_q  <= res_vld;
			res_slot_q <= res_slot;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_out   = res_slot_q;
	assign slot_valid = res_vld_q;

	`LBQ_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "accepted while busy")
	`LBQ_ASSERT_NOW(a_empty_result_zero, out_valid && !slot_valid, slot_out == '0,
		"empty result carries a slot")
	`LBQ_ASSERT_NOW(a_free_head_range, 1'b1, free_head_q <= NULL_LINK,
		"free list head out of range")
	`LBQ_ASSERT_NOW(a_link_rw_apart, lreq.wr && lreq.rd, lreq.wr_addr != lreq.rd_addr,
		"link read and write collide")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for linked_buffer_queue_manager_unit: a directed table,
// then random allocate, free, enqueue and dequeue transactions checked against a
// predictor of the free list and mailbox queues. Depends on lbq_pkg and the RTL.
module testbench;
	import lbq_pkg::*;

	typedef struct packed {
		slot_t slot;
		logic  ok;
	} result_t;

	typedef struct packed {
		req_t  op;
		mb_t   mb;
		slot_t slot;
		logic  typed;
		slot_t want_slot;
		logic  want_ok;
	} directed_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_ALLOC;
	mb_t         mailbox_idx = '0;
	slot_t       slot_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	slot_t       slot_out;
	logic        slot_valid;

	// predicted pool state
	link_t   link_of [SLOT_COUNT];
	link_t   free_top;
	link_t   mbox_head [MAILBOX_COUNT];
	link_t   mbox_tail [MAILBOX_COUNT];

	result_t awaited [$];
	slot_t   held [$];
	result_t arrived;
	int      errors = 0;
	bit      idling_on = 1'b1;
	int      stall_left = 0;

	directed_t directed_steps [DIRECTED_ROWS] = '{
		'{REQ_ALLOC, 4'd0,  6'd0,  1'b1, 6'd63, 1'b1},
		'{REQ_ALLOC, 4'd15, 6'd63, 1'b1, 6'd62, 1'b1},
		'{REQ_DEQ,   4'd0,  6'd0,  1'b1, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd15, 6'd63, 1'b1, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd15, 6'd63, 1'b1, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd15, 6'd62, 1'b1, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd15, 6'd0,  1'b0, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd0,  6'd63, 1'b1, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd15, 6'd21, 1'b0, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd15, 6'd42, 1'b0, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd0,  6'd0,  1'b0, 6'd0,  1'b0},
		'{REQ_FREE,  4'd5,  6'd63, 1'b1, 6'd0,  1'b0},
		'{REQ_FREE,  4'd10, 6'd62, 1'b1, 6'd0,  1'b0},
		'{REQ_ALLOC, 4'd3,  6'd12, 1'b0, 6'd0,  1'b0},
		'{REQ_ALLOC, 4'd12, 6'd51, 1'b0, 6'd0,  1'b0},
		'{REQ_ALLOC, 4'd0,  6'd0,  1'b0, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd7,  6'd0,  1'b1, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd7,  6'd0,  1'b0, 6'd0,  1'b0},
		'{REQ_FREE,  4'd8,  6'd0,  1'b1, 6'd0,  1'b0},
		'{REQ_ALLOC, 4'd9,  6'd33, 1'b0, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd10, 6'd61, 1'b1, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd10, 6'd63, 1'b1, 6'd0,  1'b0},
		'{REQ_ENQ,   4'd10, 6'd62, 1'b1, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd10, 6'd0,  1'b0, 6'd0,  1'b0},
		'{REQ_DEQ,   4'd10, 6'd63, 1'b0, 6'd0,  1'b0}
	};

	linked_buffer_queue_manager_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.mailbox_idx(mailbox_idx),
		.slot_in(slot_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_out(slot_out),
		.slot_valid(slot_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void reset_pool();
		link_of[0] = NULL_LINK;
		for (int i = 1; i < SLOT_COUNT; i++)
			link_of[i] = link_t'(i - 1);
		free_top = link_t'(SLOT_COUNT - 1);
		for (int i = 0; i < MAILBOX_COUNT; i++) begin
			mbox_head[i] = NULL_LINK;
			mbox_tail[i] = NULL_LINK;
		end
	endfunction

	// one request against the pool; returns the slot handed out, if any
	function automatic result_t apply_request(input req_t op, input mb_t mb, input slot_t s);
		link_t   taken;
		link_t   nxt;
		result_t res;
		taken = NULL_LINK;
		case (op)
			REQ_ALLOC: begin
				if (free_top != NULL_LINK) begin
					taken = free_top;
					free_top = link_of[taken[SLOT_W-1:0]];
					link_of[taken[SLOT_W-1:0]] = NULL_LINK;
				end
			end
			REQ_FREE: begin
				link_of[s] = free_top;
				free_top = link_t'(s);
			end
			REQ_ENQ: begin
				link_of[s] = NULL_LINK;
				if (mbox_tail[mb] != NULL_LINK)
					link_of[mbox_tail[mb][SLOT_W-1:0]] = link_t'(s);
				else
					mbox_head[mb] = link_t'(s);
				mbox_tail[mb] = link_t'(s);
			end
			default: begin
				if (mbox_head[mb] != NULL_LINK) begin
					taken = mbox_head[mb];
					nxt = link_of[taken[SLOT_W-1:0]];
					if (nxt != NULL_LINK) begin
						mbox_head[mb] = nxt;
					end else begin
						mbox_head[mb] = NULL_LINK;
						mbox_tail[mb] = NULL_LINK;
					end
					link_of[taken[SLOT_W-1:0]] = NULL_LINK;
				end
			end
		endcase
		res.ok = (taken != NULL_LINK);
		res.slot = res.ok ? taken[SLOT_W-1:0] : '0;
		return res;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic issue(input req_t op, input mb_t mb, input slot_t s, input logic typed,
		input result_t typed_res);
		result_t guess;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		mailbox_idx <= mb;
		slot_in <= s;
		do @(posedge clk); while (!in_ready);
		guess = apply_request(op, mb, s);
		if (guess.ok)
			held.push_back(guess.slot);
		awaited.push_back(typed ? typed_res : guess);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (idling_on && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result transaction slot_out %0d slot_valid %0b",
					$time, slot_out, slot_valid);
				errors++;
			end else begin
				arrived = awaited.pop_front();
				if (slot_out !== arrived.slot) begin
					$display("%0t: slot_out expected %0d got %0d", $time, arrived.slot, slot_out);
					errors++;
				end
				if (slot_valid !== arrived.ok) begin
					$display("%0t: slot_valid expected %0b got %0b", $time, arrived.ok, slot_valid);
					errors++;
				end
			end
		end
	end

	initial begin
		req_t  op;
		mb_t   mb;
		slot_t s;
		int    pick;
		int    k;
		int    phase_len;
		bit    filling;
		reset_pool();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_steps[i])
			issue(directed_steps[i].op, directed_steps[i].mb, directed_steps[i].slot,
				directed_steps[i].typed,
				'{directed_steps[i].want_slot, directed_steps[i].want_ok});

		// fill phases drain the free list, empty phases return slots to it
		filling = 1'b1;
		phase_len = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			if (n >= RANDOM_ITEMS - 60)
				idling_on = 1'b0;
			if (filling && (free_top == NULL_LINK || phase_len > 120)) begin
				filling = 1'b0;
				phase_len = 0;
			end else if (!filling && phase_len > 80) begin
				filling = 1'b1;
				phase_len = 0;
			end
			phase_len++;
			mb = ($urandom_range(0, 1) != 0) ? mb_t'($urandom_range(0, 3)) : mb_t'($urandom);
			s = slot_t'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				op = req_t'($urandom_range(0, 3));
			end else begin
				pick = $urandom_range(0, 99);
				if (filling) begin
					if (pick < 50) op = REQ_ALLOC;
					else if (pick < 72) op = REQ_ENQ;
					else if (pick < 92) op = REQ_DEQ;
					else op = REQ_FREE;
				end else begin
					if (pick < 12) op = REQ_ALLOC;
					else if (pick < 40) op = REQ_ENQ;
					else if (pick < 70) op = REQ_DEQ;
					else op = REQ_FREE;
				end
				if (op == REQ_ENQ || op == REQ_FREE) begin
					if (held.size() == 0) begin
						op = filling ? REQ_ALLOC : REQ_DEQ;
					end else begin
						k = $urandom_range(0, held.size() - 1);
						s = held[k];
						held.delete(k);
					end
				end
			end
			issue(op, mb, s, 1'b0, '0);
		end
		in_valid <= 1'b0;

		wait (awaited.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
